// File: sv/kve_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keyword/value extractor.
// No dependencies; imported by every other file of the block.
package kve_pkg;

    // result kinds
    localparam logic [1:0] KIND_VALUE   = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_NODELIM = 2'd2;

    // characters the scanner reacts to
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NL      = 8'h0A;

    // configuration register indexes
    localparam logic [1:0] CFG_KEY_BYTES    = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH   = 2'd1;
    localparam logic [1:0] CFG_DELIM_BYTES  = 2'd2;
    localparam logic [1:0] CFG_DELIM_LENGTH = 2'd3;

    localparam int CFG_DATA_W = 64;

    // configuration as seen by the scanner, lengths already clamped
    typedef struct packed {
        logic [63:0] key_bytes;
        logic [3:0]  klen;
        logic [31:0] delim_bytes;
        logic [2:0]  dlen;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data;
    } t_result;

endpackage

// File: sv/keyword_value_extractor.sv
`timescale 1ns / 1ps
// Keyword/value extractor: streams the value that follows a keyword and delimiter.
// Depends on kve_pkg, kve_cfg_regs and kve_scan.
//
// Usage:
//   Input channel i_valid/o_stall carries one text byte per beat on i_in_byte.
//   Output channel o_valid/i_stall carries zero or one result per input byte:
//   o_out_kind 0 is a value byte (o_out_byte), 1 ends the value at a newline,
//   2 flags a keyword line that had no delimiter. After kind 1 or 2 the block
//   drops all further input until reset.
//   Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data while
//   the block is idle: index 0 keyword bytes, 1 keyword length, 2 delimiter
//   bytes, 3 delimiter length.
//   A result passes from the input register to the result register before it
//   is presented on o_valid. Throughput: one byte per cycle while the receiver
//   does not stall; the scanner state advances in the same cycle that the
//   byte's result is loaded into the result register.
//   When the receiver stalls, the result register holds and one further byte
//   waits in the input register; o_stall rises only when both are full.
//   Synchronous reset clears the scanner state, both valid flags and the
//   configuration to keyword length 1, delimiter length 1, all bytes zero.
module keyword_value_extractor #(
    parameter int KEY_MAX   = 8,
    parameter int DELIM_MAX = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_in_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_out_kind,
    output logic [7:0]                     o_out_byte,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [kve_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kve_pkg::*;

    t_cfg       cfg;
    t_result    res;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [1:0] r_out_kind;
    logic [7:0] r_out_byte;
    logic       out_free;
    logic       fire;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    kve_cfg_regs #(
        .KEY_MAX   (KEY_MAX),
        .DELIM_MAX (DELIM_MAX)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    kve_scan #(
        .KEY_MAX   (KEY_MAX),
        .DELIM_MAX (DELIM_MAX)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // input register: load on an accepted beat, empty when the scanner takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall)
            r_in_byte <= i_in_byte;
    end

    // result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res.valid) begin
            r_out_kind <= res.kind;
            r_out_byte <= res.data;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_kind = r_out_kind;
    assign o_out_byte = r_out_byte;

endmodule

// File: sv/kve_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration registers of the keyword/value extractor with length clamping.
// Depends on kve_pkg.
module kve_cfg_regs #(
    parameter int KEY_MAX   = 8,
    parameter int DELIM_MAX = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [kve_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output kve_pkg::t_cfg                 o_cfg
);
    import kve_pkg::*;

    logic [63:0] r_key_bytes;
    logic [3:0]  r_key_length;
    logic [31:0] r_delim_bytes;
    logic [2:0]  r_delim_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes    <= '0;
            r_key_length   <= 4'd1;
            r_delim_bytes  <= '0;
            r_delim_length <= 3'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_BYTES:    r_key_bytes    <= i_cfg_data[63:0];
                CFG_KEY_LENGTH:   r_key_length   <= i_cfg_data[3:0];
                CFG_DELIM_BYTES:  r_delim_bytes  <= i_cfg_data[31:0];
                CFG_DELIM_LENGTH: r_delim_length <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, anything above the maximum acts as the maximum
    always_comb begin
        o_cfg.key_bytes   = r_key_bytes;
        o_cfg.delim_bytes = r_delim_bytes;
        if (r_key_length == 4'd0)
            o_cfg.klen = 4'd1;
        else if ({1'b0, r_key_length} > 5'(KEY_MAX))
            o_cfg.klen = 4'(KEY_MAX);
        else
            o_cfg.klen = r_key_length;
        if (r_delim_length == 3'd0)
            o_cfg.dlen = 3'd1;
        else if ({1'b0, r_delim_length} > 4'(DELIM_MAX))
            o_cfg.dlen = 3'(DELIM_MAX);
        else
            o_cfg.dlen = r_delim_length;
    end

endmodule

// File: sv/kve_scan.sv
`timescale 1ns / 1ps
// Scanner state and per-byte next-state logic: keyword, delimiter, capture.
// Depends on kve_pkg; fed by kve_cfg_regs.
module kve_scan #(
    parameter int KEY_MAX   = 8,
    parameter int DELIM_MAX = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  kve_pkg::t_cfg     i_cfg,
    output kve_pkg::t_result  o_res
);
    import kve_pkg::*;

    localparam int KPW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int DPW = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1;

    logic [KPW-1:0] r_key_pos,   n_key_pos;
    logic           r_key_seen,  n_key_seen;
    logic [DPW-1:0] r_delim_pos, n_delim_pos;
    logic           r_delim_seen, n_delim_seen;
    logic           r_capturing, n_capturing;
    logic           r_finished,  n_finished;

    logic [2:0] k_idx;
    logic [2:0] d_idx;
    logic [2:0] d_last_idx;
    logic [7:0] key_char;
    logic [7:0] delim_char;
    logic [7:0] delim_last;

    // delimiter bytes past the 32-bit register read as zero
    assign k_idx      = 3'(r_key_pos);
    assign d_idx      = 3'(r_delim_pos);
    assign d_last_idx = i_cfg.dlen - 3'd1;
    assign key_char   = i_cfg.key_bytes[{k_idx, 3'b000} +: 8];
    assign delim_char = d_idx[2] ? 8'h00 : i_cfg.delim_bytes[{d_idx[1:0], 3'b000} +: 8];
    assign delim_last = d_last_idx[2] ? 8'h00
                                      : i_cfg.delim_bytes[{d_last_idx[1:0], 3'b000} +: 8];

    always_comb begin
        n_key_pos    = r_key_pos;
        n_key_seen   = r_key_seen;
        n_delim_pos  = r_delim_pos;
        n_delim_seen = r_delim_seen;
        n_capturing  = r_capturing;
        n_finished   = r_finished;
        o_res        = '0;

        if (!r_finished) begin
            // keyword: restart at zero on a mismatch, byte not rechecked
            if (!r_key_seen && key_char == i_byte) begin
                if ((4'(r_key_pos) + 4'd1) >= i_cfg.klen) begin
                    n_key_pos  = '0;
                    n_key_seen = 1'b1;
                end else begin
                    n_key_pos = r_key_pos + KPW'(1);
                end
            end else begin
                n_key_pos = '0;
            end

            // delimiter sees the byte that completed the keyword
            if (n_key_seen && !r_delim_seen) begin
                if (delim_char == i_byte) begin
                    if ((4'(r_delim_pos) + 4'd1) >= {1'b0, i_cfg.dlen}) begin
                        n_delim_pos  = '0;
                        n_delim_seen = 1'b1;
                    end else begin
                        n_delim_pos = r_delim_pos + DPW'(1);
                    end
                end else begin
                    n_delim_pos = '0;
                end
            end

            if (n_key_seen && n_delim_seen) begin
                if (!r_capturing && i_byte != CHAR_SPACE && i_byte != delim_last)
                    n_capturing = 1'b1;
                if (n_capturing) begin
                    o_res.valid = 1'b1;
                    if (i_byte != CHAR_NL) begin
                        o_res.kind = KIND_VALUE;
                        o_res.data = i_byte;
                    end else begin
                        o_res.kind   = KIND_END;
                        n_capturing  = 1'b0;
                        n_delim_seen = 1'b0;
                        n_key_seen   = 1'b0;
                        n_finished   = 1'b1;
                    end
                end
            end else if (n_key_seen && i_byte == CHAR_NL) begin
                // keyword line that ended before a delimiter
                o_res.valid = 1'b1;
                o_res.kind  = KIND_NODELIM;
                n_finished  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pos    <= '0;
            r_key_seen   <= 1'b0;
            r_delim_pos  <= '0;
            r_delim_seen <= 1'b0;
            r_capturing  <= 1'b0;
            r_finished   <= 1'b0;
        end else if (i_fire) begin
            r_key_pos    <= n_key_pos;
            r_key_seen   <= n_key_seen;
            r_delim_pos  <= n_delim_pos;
            r_delim_seen <= n_delim_seen;
            r_capturing  <= n_capturing;
            r_finished   <= n_finished;
        end
    end

endmodule

// File: sv/kve_checker.sv
`timescale 1ns / 1ps
// Port-level checks for keyword_value_extractor, attached by bind.
// Depends on kve_pkg and the top level's ports.
module kve_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_out_kind,
    input logic [7:0] o_out_byte
);
    import kve_pkg::*;

    logic r_done;

    // remember that an end marker went out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (o_valid && !i_stall && o_out_kind != KIND_VALUE) begin
            r_done <= 1'b1;
        end
    end

    a_silent_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !o_valid)
        else $error("result after end marker");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_kind == KIND_VALUE || o_out_kind == KIND_END ||
                     o_out_kind == KIND_NODELIM))
        else $error("illegal result kind");

    a_marker_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_kind != KIND_VALUE) |-> o_out_byte == 8'h00)
        else $error("end marker carries a nonzero byte");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_kind) && $stable(o_out_byte)))
        else $error("stalled result changed");

endmodule

bind keyword_value_extractor kve_checker u_kve_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_kind (o_out_kind),
    .o_out_byte (o_out_byte)
);
